// ===== design/chip8_pkg.sv =====
package chip8_pkg;

  localparam int MemBytes   = 4096;
  localparam int MemAw      = 12;
  localparam int ScreenW    = 64;
  localparam int ScreenH    = 32;
  localparam int GlyphBytes = 5;

  localparam logic [2:0] ACT_EXEC  = 3'd0;
  localparam logic [2:0] ACT_WRMEM = 3'd1;
  localparam logic [2:0] ACT_RDMEM = 3'd2;
  localparam logic [2:0] ACT_RDREG = 3'd3;
  localparam logic [2:0] ACT_RDROW = 3'd4;

  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_OVER  = 2'd1;
  localparam logic [1:0] FLT_UNDER = 2'd2;
  localparam logic [1:0] FLT_UNK   = 2'd3;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEK  = 4'h3;
  localparam logic [3:0] OP_SNEK = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDK  = 4'h6;
  localparam logic [3:0] OP_ADDK = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] KK_SKP  = 8'h9E;
  localparam logic [7:0] KK_SKNP = 8'hA1;

  localparam logic [7:0] FX_GDT  = 8'h07;
  localparam logic [7:0] FX_WKEY = 8'h0A;
  localparam logic [7:0] FX_SDT  = 8'h15;
  localparam logic [7:0] FX_SST  = 8'h18;
  localparam logic [7:0] FX_ADDI = 8'h1E;
  localparam logic [7:0] FX_FONT = 8'h29;
  localparam logic [7:0] FX_BCD  = 8'h33;
  localparam logic [7:0] FX_STR  = 8'h55;
  localparam logic [7:0] FX_LDR  = 8'h65;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic [7:0]  flag_value;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;
    logic [7:0]  read_byte;
    logic [63:0] row_bits;
    logic        redraw;
    logic        waiting_key;
    logic [1:0]  fault;
  } result_t;

  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [7:0]  h;
    logic [7:0]  rem;
    logic [15:0] prod;
    logic [7:0]  t;
    logic [7:0]  u;
    h    = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
    rem  = v - 8'(h * 8'd100);
    prod = 16'(rem) * 16'd205;
    t    = 8'(prod >> 11);
    u    = rem - 8'(t * 8'd10);
    case (sel)
      2'd0:    bcd_digit = h;
      2'd1:    bcd_digit = t;
      default: bcd_digit = u;
    endcase
  endfunction

endpackage

// ===== design/chip8_if.sv =====
interface chip8_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] opcode_word;
  logic [11:0] target_address;
  logic [7:0]  write_byte;
  logic [15:0] keys_pressed;
  logic [7:0]  random_value;
  modport source (output valid, action, opcode_word, target_address, write_byte,
                  keys_pressed, random_value, input ready);
  modport sink (input valid, action, opcode_word, target_address, write_byte,
                keys_pressed, random_value, output ready);
endinterface

interface chip8_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] program_counter;
  logic [15:0] index_value;
  logic [7:0]  flag_value;
  logic [7:0]  delay_value;
  logic [7:0]  sound_value;
  logic [7:0]  read_byte;
  logic [63:0] row_bits;
  logic        redraw;
  logic        waiting_key;
  logic [1:0]  fault;
  modport source (output valid, program_counter, index_value, flag_value, delay_value,
                  sound_value, read_byte, row_bits, redraw, waiting_key, fault,
                  input ready);
  modport sink (input valid, program_counter, index_value, flag_value, delay_value,
                sound_value, read_byte, row_bits, redraw, waiting_key, fault,
                output ready);
endinterface

// ===== design/chip8_ram.sv =====
module chip8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    addr_i,
  input  logic             we_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/chip8_instruction_execute.sv =====
// Channel  Modport  Direction  Moves per transfer
// in_i     sink     input      one action with opcode, address, data, keys, random byte
// out_o    source   output     one status snapshot with read data and flags
//
// Most actions pass the register reads, an execute step and a done step; sprite draw adds
// a sprite and frame read and a frame write per drawn row and a flag write, BCD store a write
// per digit, and block store or load a read and a write per register: the arrays are single-port.
// Reset clears registers and frame through valid bits at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken.
module chip8_instruction_execute import chip8_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  chip8_in_if.sink    in_i,
  chip8_out_if.source out_o
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_EXEC = 4'd3;
  localparam logic [3:0] S_RET  = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DWR  = 4'd6;
  localparam logic [3:0] S_BCD  = 4'd7;
  localparam logic [3:0] S_SRD  = 4'd8;
  localparam logic [3:0] S_SWR  = 4'd9;
  localparam logic [3:0] S_LRD  = 4'd10;
  localparam logic [3:0] S_LWR  = 4'd11;
  localparam logic [3:0] S_VF   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0]  state_q, state_d;
  logic [11:0] pc_q, pc_d;
  logic [15:0] idx_q, idx_d;
  logic [7:0]  dt_q, dt_d, st_q, st_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [7:0]  vf_q;
  logic [2:0]  act_q, act_d;
  logic [15:0] op_q, op_d;
  logic [11:0] tgt_q, tgt_d;
  logic [7:0]  wb_q, wb_d;
  logic [15:0] keys_q, keys_d;
  logic [7:0]  rnd_q, rnd_d;
  logic [7:0]  vx_q, vx_d, vy_q, vy_d;
  logic [7:0]  rd_q, rd_d;
  logic [63:0] row_q, row_d;
  logic        redraw_q, redraw_d, wait_q, wait_d, hit_q, hit_d;
  logic [1:0]  fault_q, fault_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  result_t     res_q, res_d;

  logic [15:0] rf_vld_q;
  logic [31:0] fr_vld_q;
  logic [3:0]  rf_ra_q;
  logic [4:0]  fr_ra_q;
  logic        fr_clr;

  logic [3:0]  rf_addr;
  logic        rf_we;
  logic [7:0]  rf_wdata, rf_rdata, rf_rd;
  logic [MemAw-1:0] mem_addr;
  logic        mem_we;
  logic [7:0]  mem_wdata, mem_rdata;
  logic [4:0]  fr_addr;
  logic        fr_we;
  logic [63:0] fr_wdata, fr_rdata, fr_rd;
  logic [SAW-1:0] stk_addr;
  logic        stk_we;
  logic [11:0] stk_wdata, stk_rdata;

  logic [3:0]  x, y, n;
  logic [7:0]  kk;
  logic [11:0] nnn, pcn;
  logic [8:0]  sum9;
  logic [5:0]  rowsum;
  logic [63:0] bits;
  logic        key_hit, found;
  logic [3:0]  first_key;
  logic [SPW-1:0] sp_dec;

  chip8_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk_i, .addr_i(rf_addr), .we_i(rf_we), .wdata_i(rf_wdata), .rdata_o(rf_rdata));
  chip8_ram #(.WIDTH(8), .DEPTH(MemBytes)) u_mem (
    .clk_i, .addr_i(mem_addr), .we_i(mem_we), .wdata_i(mem_wdata), .rdata_o(mem_rdata));
  chip8_ram #(.WIDTH(ScreenW), .DEPTH(ScreenH)) u_frame (
    .clk_i, .addr_i(fr_addr), .we_i(fr_we), .wdata_i(fr_wdata), .rdata_o(fr_rdata));
  chip8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i, .addr_i(stk_addr), .we_i(stk_we), .wdata_i(stk_wdata), .rdata_o(stk_rdata));

  assign rf_rd = rf_vld_q[rf_ra_q] ? rf_rdata : 8'd0;
  assign fr_rd = fr_vld_q[fr_ra_q] ? fr_rdata : 64'd0;

  assign x      = op_q[11:8];
  assign y      = op_q[7:4];
  assign n      = op_q[3:0];
  assign kk     = op_q[7:0];
  assign nnn    = op_q[11:0];
  assign pcn    = pc_q + 12'd2;
  assign sum9   = {1'b0, vx_q} + {1'b0, vy_q};
  assign rowsum = {1'b0, vy_q[4:0]} + {2'b00, cnt_q};
  assign bits   = {mem_rdata, 56'd0} >> vx_q[5:0];
  assign key_hit = (vx_q[7:4] == 4'd0) && keys_q[vx_q[3:0]];
  assign sp_dec = sp_q - SPW'(1);

  always_comb begin
    found     = 1'b0;
    first_key = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (keys_q[i]) begin
        found     = 1'b1;
        first_key = 4'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;  pc_d = pc_q;  idx_d = idx_q;  dt_d = dt_q;  st_d = st_q;
    sp_d = sp_q;  act_d = act_q;  op_d = op_q;  tgt_d = tgt_q;  wb_d = wb_q;
    keys_d = keys_q;  rnd_d = rnd_q;  vx_d = vx_q;  vy_d = vy_q;  rd_d = rd_q;
    row_d = row_q;  redraw_d = redraw_q;  wait_d = wait_q;  hit_d = hit_q;
    fault_d = fault_q;  cnt_d = cnt_q;  res_d = res_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    rf_addr = rf_ra_q;  rf_we = 1'b0;  rf_wdata = 8'd0;
    mem_addr = '0;  mem_we = 1'b0;  mem_wdata = 8'd0;
    fr_addr = fr_ra_q;  fr_we = 1'b0;  fr_wdata = 64'd0;  fr_clr = 1'b0;
    stk_addr = '0;  stk_we = 1'b0;  stk_wdata = 12'd0;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          act_d = in_i.action;  op_d = in_i.opcode_word;  tgt_d = in_i.target_address;
          wb_d = in_i.write_byte;  keys_d = in_i.keys_pressed;  rnd_d = in_i.random_value;
          rd_d = 8'd0;  row_d = 64'd0;  redraw_d = 1'b0;  wait_d = 1'b0;
          fault_d = FLT_NONE;
          rf_addr = (in_i.action == ACT_RDREG) ? in_i.target_address[3:0]
                                               : in_i.opcode_word[11:8];
          mem_addr = in_i.target_address;
          fr_addr  = in_i.target_address[4:0];
          state_d  = S_RDA;
        end
      end
      S_RDA: begin
        vx_d = rf_rd;
        case (act_q)
          ACT_RDMEM: rd_d = mem_rdata;
          ACT_RDREG: rd_d = (tgt_q[11:4] == 8'd0) ? rf_rd : 8'd0;
          ACT_RDROW: row_d = (tgt_q[11:5] == 7'd0) ? fr_rd : 64'd0;
          default: ;
        endcase
        rf_addr = (op_q[15:12] == OP_JPV0) ? 4'h0 : y;
        state_d = S_RDB;
      end
      S_RDB: begin
        vy_d    = rf_rd;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (act_q)
          ACT_WRMEM: begin
            mem_addr = tgt_q;  mem_we = 1'b1;  mem_wdata = wb_q;
          end
          ACT_EXEC: begin
            pc_d = pcn;
            case (op_q[15:12])
              OP_SYS: begin
                if (op_q == OP_CLS) begin
                  fr_clr = 1'b1;  redraw_d = 1'b1;
                end else if (op_q == OP_RET) begin
                  if (sp_q == '0) begin
                    fault_d = FLT_UNDER;
                  end else begin
                    sp_d = sp_dec;  stk_addr = sp_dec[SAW-1:0];  state_d = S_RET;
                  end
                end else begin
                  fault_d = FLT_UNK;
                end
              end
              OP_JP: pc_d = nnn;
              OP_CALL: begin
                if (sp_q >= SPW'(STACK_DEPTH)) begin
                  fault_d = FLT_OVER;
                end else begin
                  stk_addr = sp_q[SAW-1:0];  stk_we = 1'b1;  stk_wdata = pcn;
                  sp_d = sp_q + SPW'(1);  pc_d = nnn;
                end
              end
              OP_SEK:  if (vx_q == kk) pc_d = pcn + 12'd2;
              OP_SNEK: if (vx_q != kk) pc_d = pcn + 12'd2;
              OP_SER: begin
                if (n != 4'd0) fault_d = FLT_UNK;
                else if (vx_q == vy_q) pc_d = pcn + 12'd2;
              end
              OP_SNER: begin
                if (n != 4'd0) fault_d = FLT_UNK;
                else if (vx_q != vy_q) pc_d = pcn + 12'd2;
              end
              OP_LDK: begin
                rf_addr = x;  rf_we = 1'b1;  rf_wdata = kk;
              end
              OP_ADDK: begin
                rf_addr = x;  rf_we = 1'b1;  rf_wdata = vx_q + kk;
              end
              OP_ALU: begin
                rf_addr = x;  rf_we = 1'b1;  state_d = S_VF;
                case (n)
                  ALU_MOV: begin rf_wdata = vy_q;         state_d = S_DONE; end
                  ALU_OR:  begin rf_wdata = vx_q | vy_q;  state_d = S_DONE; end
                  ALU_AND: begin rf_wdata = vx_q & vy_q;  state_d = S_DONE; end
                  ALU_XOR: begin rf_wdata = vx_q ^ vy_q;  state_d = S_DONE; end
                  ALU_ADD: begin rf_wdata = sum9[7:0];    hit_d = sum9[8]; end
                  ALU_SUB: begin rf_wdata = vx_q - vy_q;  hit_d = vx_q >= vy_q; end
                  ALU_SHR: begin rf_wdata = vx_q >> 1;    hit_d = vx_q[0]; end
                  ALU_SBN: begin rf_wdata = vy_q - vx_q;  hit_d = vy_q >= vx_q; end
                  ALU_SHL: begin rf_wdata = vx_q << 1;    hit_d = vx_q[7]; end
                  default: begin
                    rf_we = 1'b0;  fault_d = FLT_UNK;  state_d = S_DONE;
                  end
                endcase
              end
              OP_LDI:  idx_d = {4'd0, nnn};
              OP_JPV0: pc_d = {4'd0, vy_q} + nnn;
              OP_RND: begin
                rf_addr = x;  rf_we = 1'b1;  rf_wdata = rnd_q & kk;
              end
              OP_DRW: begin
                cnt_d = 4'd0;  hit_d = 1'b0;  state_d = S_DRD;
              end
              OP_KEY: begin
                if (kk == KK_SKP) begin
                  if (key_hit) pc_d = pcn + 12'd2;
                end else if (kk == KK_SKNP) begin
                  if (!key_hit) pc_d = pcn + 12'd2;
                end else begin
                  fault_d = FLT_UNK;
                end
              end
              default: begin
                case (kk)
                  FX_GDT: begin
                    rf_addr = x;  rf_we = 1'b1;  rf_wdata = dt_q;
                  end
                  FX_WKEY: begin
                    if (found) begin
                      rf_addr = x;  rf_we = 1'b1;  rf_wdata = {4'd0, first_key};
                    end else begin
                      pc_d = pc_q;  wait_d = 1'b1;
                    end
                  end
                  FX_SDT:  dt_d = vx_q;
                  FX_SST:  st_d = vx_q;
                  FX_ADDI: idx_d = idx_q + {8'd0, vx_q};
                  FX_FONT: idx_d = 16'({4'd0, vx_q[3:0]} * 8'(GlyphBytes));
                  FX_BCD:  begin cnt_d = 4'd0;  state_d = S_BCD; end
                  FX_STR:  begin cnt_d = 4'd0;  state_d = S_SRD; end
                  FX_LDR:  begin cnt_d = 4'd0;  state_d = S_LRD; end
                  default: fault_d = FLT_UNK;
                endcase
              end
            endcase
          end
          default: ;
        endcase
      end
      S_RET: begin
        pc_d    = stk_rdata;
        state_d = S_DONE;
      end
      S_DRD: begin
        if ((cnt_q == n) || rowsum[5]) begin
          redraw_d = 1'b1;  state_d = S_VF;
        end else begin
          mem_addr = idx_q[MemAw-1:0] + {8'd0, cnt_q};
          fr_addr  = rowsum[4:0];
          state_d  = S_DWR;
        end
      end
      S_DWR: begin
        hit_d    = hit_q | (|(fr_rd & bits));
        fr_addr  = fr_ra_q;  fr_we = 1'b1;  fr_wdata = fr_rd ^ bits;
        cnt_d    = cnt_q + 4'd1;
        state_d  = S_DRD;
      end
      S_BCD: begin
        mem_addr  = idx_q[MemAw-1:0] + {8'd0, cnt_q};
        mem_we    = 1'b1;
        mem_wdata = bcd_digit(vx_q, cnt_q[1:0]);
        cnt_d     = cnt_q + 4'd1;
        if (cnt_q == 4'd2) state_d = S_DONE;
      end
      S_SRD: begin
        rf_addr = cnt_q;
        state_d = S_SWR;
      end
      S_SWR: begin
        mem_addr  = idx_q[MemAw-1:0] + {8'd0, cnt_q};
        mem_we    = 1'b1;
        mem_wdata = rf_rd;
        cnt_d     = cnt_q + 4'd1;
        state_d   = (cnt_q == x) ? S_DONE : S_SRD;
      end
      S_LRD: begin
        mem_addr = idx_q[MemAw-1:0] + {8'd0, cnt_q};
        state_d  = S_LWR;
      end
      S_LWR: begin
        rf_addr  = cnt_q;  rf_we = 1'b1;  rf_wdata = mem_rdata;
        cnt_d    = cnt_q + 4'd1;
        state_d  = (cnt_q == x) ? S_DONE : S_LRD;
      end
      S_VF: begin
        rf_addr = 4'hF;  rf_we = 1'b1;  rf_wdata = {7'd0, hit_q};
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d           = 1'b1;
          res_d.program_counter = pc_q;
          res_d.index_value     = idx_q;
          res_d.flag_value      = vf_q;
          res_d.delay_value     = dt_q;
          res_d.sound_value     = st_q;
          res_d.read_byte       = rd_q;
          res_d.row_bits        = row_q;
          res_d.redraw          = redraw_q;
          res_d.waiting_key     = wait_q;
          res_d.fault           = fault_q;
          state_d               = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= 12'd512;
      idx_q       <= 16'd0;
      dt_q        <= 8'd0;
      st_q        <= 8'd0;
      sp_q        <= '0;
      vf_q        <= 8'd0;
      rf_vld_q    <= '0;
      fr_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      dt_q        <= dt_d;
      st_q        <= st_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
      if (rf_we) begin
        rf_vld_q[rf_addr] <= 1'b1;
        if (rf_addr == 4'hF) vf_q <= rf_wdata;
      end
      if (fr_clr) begin
        fr_vld_q <= '0;
      end else if (fr_we) begin
        fr_vld_q[fr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;   op_q    <= op_d;    tgt_q   <= tgt_d;   wb_q   <= wb_d;
    keys_q   <= keys_d;  rnd_q   <= rnd_d;   vx_q    <= vx_d;    vy_q   <= vy_d;
    rd_q     <= rd_d;    row_q   <= row_d;   redraw_q <= redraw_d;
    wait_q   <= wait_d;  hit_q   <= hit_d;   fault_q <= fault_d; cnt_q  <= cnt_d;
    res_q    <= res_d;   rf_ra_q <= rf_addr; fr_ra_q <= fr_addr;
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.program_counter = res_q.program_counter;
  assign out_o.index_value     = res_q.index_value;
  assign out_o.flag_value      = res_q.flag_value;
  assign out_o.delay_value     = res_q.delay_value;
  assign out_o.sound_value     = res_q.sound_value;
  assign out_o.read_byte       = res_q.read_byte;
  assign out_o.row_bits        = res_q.row_bits;
  assign out_o.redraw          = res_q.redraw;
  assign out_o.waiting_key     = res_q.waiting_key;
  assign out_o.fault           = res_q.fault;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == S_RDA)
    else $error("accepted transfer did not start the read phase");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack depth beyond its limit");

  a_vf_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we && rf_addr == 4'hF |=> vf_q == $past(rf_wdata))
    else $error("flag copy out of step with register file");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && (!out_valid_q || out_o.ready) |=> out_valid_q)
    else $error("finished item not presented");

endmodule
